@@ design/http_chunked_deframer_defines.svh @@
// Assertion macros for the deframer core.
`ifndef HTTP_CHUNKED_DEFRAMER_DEFINES_SVH
`define HTTP_CHUNKED_DEFRAMER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hcd check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define HCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hcd check failed one cycle later");

`endif

@@ design/hcd_pkg.sv @@
package hcd_pkg;

    localparam int DEF_MAX_CHUNK_BYTES = 65536;
    localparam int DEF_SIZE_LINE_BYTES = 20;

    localparam int CHUNK_COUNT_W = 16;
    localparam int TRAIL_BYTES   = 2;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_LOWER_X = 8'h78;
    localparam logic [7:0] CHAR_UPPER_X = 8'h58;

    typedef enum logic [1:0] {
        PH_LINE  = 2'd0,
        PH_DATA  = 2'd1,
        PH_TRAIL = 2'd2,
        PH_DONE  = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        HX_SKIP      = 3'd0,
        HX_ZERO      = 3'd1,
        HX_AFTERX    = 3'd2,
        HX_DIGITS    = 3'd3,
        HX_STOP_OK   = 3'd4,
        HX_STOP_NONE = 3'd5
    } hex_state_t;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       closed;
    } in_item_t;

    typedef struct packed {
        kind_t                     kind;
        logic [7:0]                payload;
        logic                      last_in_chunk;
        logic [CHUNK_COUNT_W-1:0]  chunk_number;
    } result_t;

    // Bit 4 flags a hex digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0B) || (c == 8'h0C);
    endfunction

endpackage

@@ design/hcd_in_stage.sv @@
module hcd_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // rx_byte
    input  logic [0:0]          s_axis_tuser,   // closed
    input  logic                take,
    output logic                item_valid,
    output hcd_pkg::in_item_t   item
);

    logic              valid_reg;
    logic              valid_next;
    hcd_pkg::in_item_t item_reg;

    // The register frees up in the same cycle that the core consumes it.
    assign s_axis_tready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_axis_tready)
        begin
            valid_next = s_axis_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            item_reg.rx_byte <= s_axis_tdata;
            item_reg.closed  <= s_axis_tuser[0];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ design/hcd_core.sv @@
`include "http_chunked_deframer_defines.svh"

module hcd_core
#(
    parameter int MAX_CHUNK_BYTES = hcd_pkg::DEF_MAX_CHUNK_BYTES,
    parameter int SIZE_LINE_BYTES = hcd_pkg::DEF_SIZE_LINE_BYTES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  hcd_pkg::in_item_t  item,
    output logic               emit,
    output hcd_pkg::result_t   result
);

    localparam int SIZE_W = $clog2(MAX_CHUNK_BYTES + 2);
    localparam int LC_W   = $clog2(SIZE_LINE_BYTES + 1);
    localparam logic [SIZE_W-1:0] SIZE_HOLD = SIZE_W'(MAX_CHUNK_BYTES + 1);
    localparam logic [SIZE_W:0]   SIZE_MAX1 = (SIZE_W + 1)'(MAX_CHUNK_BYTES);
    localparam logic [SIZE_W+3:0] SIZE_MAX4 = (SIZE_W + 4)'(MAX_CHUNK_BYTES);

    hcd_pkg::phase_t                     phase_reg, phase_next;
    hcd_pkg::hex_state_t                 hex_reg, hex_next;
    logic [LC_W-1:0]                     line_count_reg, line_count_next;
    logic [SIZE_W-1:0]                   accum_reg, accum_next;
    logic                                too_big_reg, too_big_next;
    logic [SIZE_W-1:0]                   remaining_reg, remaining_next;
    logic [hcd_pkg::CHUNK_COUNT_W-1:0]   chunk_reg, chunk_next;

    logic [4:0]          digit;
    logic                is_digit;
    logic [SIZE_W+3:0]   add_val;
    logic                add_big;
    logic                do_add;
    logic [LC_W-1:0]     lc_inc;
    logic [7:0]          c;

    assign c        = item.rx_byte;
    assign digit    = hcd_pkg::hex_digit(c);
    assign is_digit = digit[4];
    assign add_val  = {accum_reg, 4'b0000} + (SIZE_W + 4)'(digit[3:0]);
    assign add_big  = add_val > SIZE_MAX4;
    assign lc_inc   = line_count_reg + LC_W'(1);

    always_comb
    begin
        phase_next      = phase_reg;
        hex_next        = hex_reg;
        line_count_next = line_count_reg;
        accum_next      = accum_reg;
        too_big_next    = too_big_reg;
        remaining_next  = remaining_reg;
        chunk_next      = chunk_reg;
        do_add          = 1'b0;
        emit            = 1'b0;
        result.kind          = hcd_pkg::KIND_DATA;
        result.payload       = 8'd0;
        result.last_in_chunk = 1'b0;
        result.chunk_number  = chunk_reg;

        if (fire && phase_reg != hcd_pkg::PH_DONE)
        begin
            if (item.closed)
            begin
                emit        = 1'b1;
                result.kind = hcd_pkg::KIND_ERR;
            end
            else
            begin
                unique case (phase_reg)
                    hcd_pkg::PH_LINE:
                    begin
                        if (c == hcd_pkg::CHAR_NEWLINE)
                        begin
                            if (hex_reg == hcd_pkg::HX_SKIP || hex_reg == hcd_pkg::HX_STOP_NONE)
                            begin
                                emit        = 1'b1;
                                result.kind = hcd_pkg::KIND_ERR;
                            end
                            else if (!too_big_reg && accum_reg == '0)
                            begin
                                emit        = 1'b1;
                                result.kind = hcd_pkg::KIND_END;
                            end
                            else if (too_big_reg
                                     || ({1'b0, accum_reg} + (SIZE_W + 1)'(2)) > SIZE_MAX1)
                            begin
                                emit        = 1'b1;
                                result.kind = hcd_pkg::KIND_ERR;
                            end
                            else
                            begin
                                remaining_next = accum_reg;
                                chunk_next     = chunk_reg + hcd_pkg::CHUNK_COUNT_W'(1);
                                phase_next     = hcd_pkg::PH_DATA;
                            end
                        end
                        else
                        begin
                            line_count_next = lc_inc;
                            if (lc_inc >= LC_W'(SIZE_LINE_BYTES))
                            begin
                                emit        = 1'b1;
                                result.kind = hcd_pkg::KIND_ERR;
                            end
                            else
                            begin
                                unique case (hex_reg)
                                    hcd_pkg::HX_SKIP:
                                    begin
                                        if (!hcd_pkg::is_blank(c))
                                        begin
                                            if (c == hcd_pkg::CHAR_ZERO)
                                            begin
                                                hex_next   = hcd_pkg::HX_ZERO;
                                                accum_next = '0;
                                            end
                                            else if (is_digit)
                                            begin
                                                hex_next = hcd_pkg::HX_DIGITS;
                                                do_add   = 1'b1;
                                            end
                                            else
                                            begin
                                                hex_next = hcd_pkg::HX_STOP_NONE;
                                            end
                                        end
                                    end
                                    hcd_pkg::HX_ZERO:
                                    begin
                                        if (c == hcd_pkg::CHAR_LOWER_X
                                            || c == hcd_pkg::CHAR_UPPER_X)
                                        begin
                                            hex_next = hcd_pkg::HX_AFTERX;
                                        end
                                        else if (is_digit)
                                        begin
                                            hex_next = hcd_pkg::HX_DIGITS;
                                            do_add   = 1'b1;
                                        end
                                        else
                                        begin
                                            hex_next = hcd_pkg::HX_STOP_OK;
                                        end
                                    end
                                    hcd_pkg::HX_AFTERX, hcd_pkg::HX_DIGITS:
                                    begin
                                        if (is_digit)
                                        begin
                                            hex_next = hcd_pkg::HX_DIGITS;
                                            do_add   = 1'b1;
                                        end
                                        else
                                        begin
                                            hex_next = hcd_pkg::HX_STOP_OK;
                                        end
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                        end
                    end
                    hcd_pkg::PH_DATA:
                    begin
                        emit                 = 1'b1;
                        result.payload       = c;
                        result.last_in_chunk = (remaining_reg <= SIZE_W'(1));
                        if (remaining_reg != '0)
                        begin
                            remaining_next = remaining_reg - SIZE_W'(1);
                        end
                        if (remaining_reg <= SIZE_W'(1))
                        begin
                            phase_next      = hcd_pkg::PH_TRAIL;
                            line_count_next = '0;
                        end
                    end
                    hcd_pkg::PH_TRAIL:
                    begin
                        line_count_next = lc_inc;
                        if (lc_inc >= LC_W'(hcd_pkg::TRAIL_BYTES))
                        begin
                            phase_next      = hcd_pkg::PH_LINE;
                            line_count_next = '0;
                            hex_next        = hcd_pkg::HX_SKIP;
                            accum_next      = '0;
                            too_big_next    = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (emit && result.kind != hcd_pkg::KIND_DATA)
            begin
                phase_next = hcd_pkg::PH_DONE;
            end
        end

        // Once the size has overflowed it is held and further digits are ignored.
        if (do_add && !too_big_reg)
        begin
            if (add_big)
            begin
                accum_next   = SIZE_HOLD;
                too_big_next = 1'b1;
            end
            else
            begin
                accum_next = add_val[SIZE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= hcd_pkg::PH_LINE;
            hex_reg        <= hcd_pkg::HX_SKIP;
            line_count_reg <= '0;
            accum_reg      <= '0;
            too_big_reg    <= 1'b0;
            remaining_reg  <= '0;
            chunk_reg      <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            hex_reg        <= hex_next;
            line_count_reg <= line_count_next;
            accum_reg      <= accum_next;
            too_big_reg    <= too_big_next;
            remaining_reg  <= remaining_next;
            chunk_reg      <= chunk_next;
        end
    end

    `HCD_ASSERT_NOW(a_done_silent, clk, rst_n, phase_reg == hcd_pkg::PH_DONE, !emit)
    `HCD_ASSERT_NEXT(a_end_is_final, clk, rst_n,
                     emit && result.kind != hcd_pkg::KIND_DATA,
                     phase_reg == hcd_pkg::PH_DONE)
    `HCD_ASSERT_NEXT(a_last_to_trail, clk, rst_n,
                     emit && result.kind == hcd_pkg::KIND_DATA && result.last_in_chunk,
                     phase_reg == hcd_pkg::PH_TRAIL)
    `HCD_ASSERT_NOW(a_data_has_bytes, clk, rst_n,
                    phase_reg == hcd_pkg::PH_DATA, remaining_reg != '0)

endmodule

@@ design/hcd_out_stage.sv @@
module hcd_out_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  hcd_pkg::result_t   result,
    output logic               slot_free,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [23:0]        m_axis_tdata,   // payload, chunk_number
    output logic [1:0]         m_axis_tuser,   // kind
    output logic               m_axis_tlast    // last_in_chunk
);

    logic             valid_reg;
    logic             valid_next;
    hcd_pkg::result_t result_reg;

    assign slot_free = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (slot_free)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && load)
        begin
            result_reg <= result;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {result_reg.chunk_number, result_reg.payload};
    assign m_axis_tuser  = result_reg.kind;
    assign m_axis_tlast  = result_reg.last_in_chunk;

endmodule

@@ design/http_chunked_deframer.sv @@
// Chunked body decoder for HTTP: takes the received body one byte per item and
// returns the payload bytes of each chunk, tagged with the chunk count and a
// last-byte mark, followed by one end or error item, after which the block is
// silent until reset. Throughput is one byte per clock unless a held result stalls
// the flow; a byte passes from the input register through the decode logic into
// the result register, from which its result is presented. Size-line and trailer
// bytes produce no output item. The input only stalls while a result is held in
// the result register by a low m_axis_tready, since all decode work is
// combinational between the two.
module http_chunked_deframer
#(
    parameter int MAX_CHUNK_BYTES = hcd_pkg::DEF_MAX_CHUNK_BYTES,
    parameter int SIZE_LINE_BYTES = hcd_pkg::DEF_SIZE_LINE_BYTES
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,    // rx_byte
    input  logic [0:0]   s_axis_tuser,    // closed
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [23:0]  m_axis_tdata,    // payload [7:0], chunk_number [23:8]
    output logic [1:0]   m_axis_tuser,    // kind
    output logic         m_axis_tlast     // last_in_chunk
);

    logic              item_valid;
    hcd_pkg::in_item_t item;
    logic              slot_free;
    logic              fire;
    logic              emit;
    hcd_pkg::result_t  result;

    assign fire = item_valid && slot_free;

    hcd_in_stage u_in
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .take          (fire),
        .item_valid    (item_valid),
        .item          (item)
    );

    hcd_core
    #(
        .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES),
        .SIZE_LINE_BYTES (SIZE_LINE_BYTES)
    )
    u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .emit   (emit),
        .result (result)
    );

    hcd_out_stage u_out
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (emit),
        .result        (result),
        .slot_free     (slot_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ test/tb_http_chunked_deframer.sv @@
`timescale 1ns / 1ps

module tb_http_chunked_deframer;

    localparam int MAX_CHUNK    = hcd_pkg::DEF_MAX_CHUNK_BYTES;
    localparam int LINE_LIMIT   = hcd_pkg::DEF_SIZE_LINE_BYTES;
    localparam int RANDOM_ITEMS = 1750;
    localparam int DIR_ROWS     = 18;
    localparam int PHASE_ITEMS  = (RANDOM_ITEMS + DIR_ROWS) / 3;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_LINES = 40;
    localparam hcd_pkg::result_t NO_RESULT = '0;

    typedef enum int {
        END_BY_ZERO        = 0,
        END_BY_PREFIX      = 1,
        END_BY_CLOSE_LINE  = 2,
        END_BY_CLOSE_DATA  = 3,
        END_BY_CLOSE_TRAIL = 4,
        END_BY_LONG_LINE   = 5,
        END_BY_NO_DIGITS   = 6,
        END_BY_TOO_BIG     = 7
    } ending_t;

    typedef struct {
        logic [7:0] rx;
        logic       cl;
    } rx_item_t;

    typedef struct {
        logic [7:0]       rx;
        logic             cl;
        bit               typed;
        hcd_pkg::result_t want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // rx_byte
    logic [0:0]  s_axis_tuser;    // closed
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;    // payload [7:0], chunk_number [23:8]
    logic [1:0]  m_axis_tuser;    // kind
    logic        m_axis_tlast;    // last_in_chunk

    http_chunked_deframer
    #(
        .MAX_CHUNK_BYTES (MAX_CHUNK),
        .SIZE_LINE_BYTES (LINE_LIMIT)
    )
    dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Decoder model state.
    hcd_pkg::phase_t      ph;
    logic [4:0]           line_cnt;
    hcd_pkg::hex_state_t  hx;
    logic [16:0]          size_acc;
    logic                 too_big;
    logic [16:0]          remain;
    logic [15:0]          chunk_cnt;

    hcd_pkg::result_t expected_results[$];
    rx_item_t         pending[$];
    dir_row_t         directed_rows [DIR_ROWS];
    ending_t          ending;
    int               mismatches;
    int               results_seen;
    int               sent_count;
    int               src_idle_pct;
    int               sink_idle_pct;

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
        return -1;
    endfunction

    function automatic bit blank_char(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0B || c == 8'h0C;
    endfunction

    function automatic void restart_size_line();
        ph       = hcd_pkg::PH_LINE;
        line_cnt = '0;
        hx       = hcd_pkg::HX_SKIP;
        size_acc = '0;
        too_big  = 1'b0;
    endfunction

    // Once the size passes the maximum it is pinned just above it and flagged.
    function automatic void take_digit(input int d);
        logic [20:0] grown;
        if (too_big) return;
        grown = {size_acc, 4'b0000} + 21'(d);
        if (grown > 21'(MAX_CHUNK))
        begin
            size_acc = 17'(MAX_CHUNK + 1);
            too_big  = 1'b1;
        end
        else
        begin
            size_acc = grown[16:0];
        end
    endfunction

    function automatic void scan_size_char(input logic [7:0] c);
        int d;
        d = nibble_of(c);
        case (hx)
            hcd_pkg::HX_SKIP:
            begin
                if (!blank_char(c))
                begin
                    if (c == hcd_pkg::CHAR_ZERO)
                    begin
                        hx       = hcd_pkg::HX_ZERO;
                        size_acc = '0;
                    end
                    else if (d >= 0)
                    begin
                        hx = hcd_pkg::HX_DIGITS;
                        take_digit(d);
                    end
                    else
                    begin
                        hx = hcd_pkg::HX_STOP_NONE;
                    end
                end
            end
            hcd_pkg::HX_ZERO:
            begin
                if (c == hcd_pkg::CHAR_LOWER_X || c == hcd_pkg::CHAR_UPPER_X)
                begin
                    hx = hcd_pkg::HX_AFTERX;
                end
                else if (d >= 0)
                begin
                    hx = hcd_pkg::HX_DIGITS;
                    take_digit(d);
                end
                else
                begin
                    hx = hcd_pkg::HX_STOP_OK;
                end
            end
            hcd_pkg::HX_AFTERX, hcd_pkg::HX_DIGITS:
            begin
                if (d >= 0)
                begin
                    hx = hcd_pkg::HX_DIGITS;
                    take_digit(d);
                end
                else
                begin
                    hx = hcd_pkg::HX_STOP_OK;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // Advances the model by one received byte; returns 1 when a result is due.
    function automatic bit decode_byte(input logic [7:0] c, input logic cl,
                                       output hcd_pkg::result_t r);
        bit last;
        r = NO_RESULT;
        r.chunk_number = chunk_cnt;
        if (ph == hcd_pkg::PH_DONE) return 1'b0;
        if (cl)
        begin
            r.kind = hcd_pkg::KIND_ERR;
            ph     = hcd_pkg::PH_DONE;
            return 1'b1;
        end
        case (ph)
            hcd_pkg::PH_LINE:
            begin
                if (c == hcd_pkg::CHAR_NEWLINE)
                begin
                    if (hx == hcd_pkg::HX_SKIP || hx == hcd_pkg::HX_STOP_NONE)
                    begin
                        r.kind = hcd_pkg::KIND_ERR;
                        ph     = hcd_pkg::PH_DONE;
                        return 1'b1;
                    end
                    if (!too_big && size_acc == 0)
                    begin
                        r.kind = hcd_pkg::KIND_END;
                        ph     = hcd_pkg::PH_DONE;
                        return 1'b1;
                    end
                    if (too_big || int'(size_acc) + hcd_pkg::TRAIL_BYTES > MAX_CHUNK)
                    begin
                        r.kind = hcd_pkg::KIND_ERR;
                        ph     = hcd_pkg::PH_DONE;
                        return 1'b1;
                    end
                    remain    = size_acc;
                    chunk_cnt = chunk_cnt + 16'd1;
                    ph        = hcd_pkg::PH_DATA;
                    return 1'b0;
                end
                line_cnt = line_cnt + 5'd1;
                if (int'(line_cnt) >= LINE_LIMIT)
                begin
                    r.kind = hcd_pkg::KIND_ERR;
                    ph     = hcd_pkg::PH_DONE;
                    return 1'b1;
                end
                scan_size_char(c);
                return 1'b0;
            end
            hcd_pkg::PH_DATA:
            begin
                last = (remain <= 1);
                if (remain > 0) remain = remain - 17'd1;
                if (remain == 0)
                begin
                    ph       = hcd_pkg::PH_TRAIL;
                    line_cnt = '0;
                end
                r.kind          = hcd_pkg::KIND_DATA;
                r.payload       = c;
                r.last_in_chunk = last;
                return 1'b1;
            end
            default:
            begin
                // The two bytes after the payload are dropped without a look.
                line_cnt = line_cnt + 5'd1;
                if (int'(line_cnt) >= hcd_pkg::TRAIL_BYTES) restart_size_line();
                return 1'b0;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        if (mismatches < REPORT_LINES)
        begin
            $display("MISMATCH at result %0d, %s: expected %0h, got %0h",
                     results_seen, field, want, got);
        end
        mismatches++;
    endtask

    task automatic check_result();
        hcd_pkg::result_t got;
        hcd_pkg::result_t want;
        got.kind          = hcd_pkg::kind_t'(m_axis_tuser);
        got.payload       = m_axis_tdata[7:0];
        got.last_in_chunk = m_axis_tlast;
        got.chunk_number  = m_axis_tdata[23:8];
        results_seen++;
        if (expected_results.size() == 0)
        begin
            report_mismatch("result with nothing pending, kind", 32'd0, 32'(m_axis_tuser));
        end
        else
        begin
            want = expected_results.pop_front();
            if (got.kind !== want.kind)
                report_mismatch("kind", 32'(want.kind), 32'(m_axis_tuser));
            if (got.payload !== want.payload)
                report_mismatch("payload", 32'(want.payload), 32'(got.payload));
            if (got.last_in_chunk !== want.last_in_chunk)
                report_mismatch("last_in_chunk", 32'(want.last_in_chunk),
                                32'(got.last_in_chunk));
            if (got.chunk_number !== want.chunk_number)
                report_mismatch("chunk_number", 32'(want.chunk_number),
                                32'(got.chunk_number));
        end
    endtask

    // Receiver: checks every accepted result and stalls at random.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready) check_result();
            m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    initial
    begin : watchdog
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall = 0;
            else
                stall++;
        end
        $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_rx(input logic [7:0] rx, input logic cl, input bit typed,
                           input hcd_pkg::result_t fixed_res);
        hcd_pkg::result_t predicted;
        bit               produces;
        if (sent_count < PHASE_ITEMS)
        begin
            src_idle_pct  = 34;
            sink_idle_pct = 54;
        end
        else if (sent_count < 2 * PHASE_ITEMS)
        begin
            src_idle_pct  = 54;
            sink_idle_pct = 34;
        end
        else
        begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
        end
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx;
        s_axis_tuser  <= cl;
        do @(posedge clk); while (!s_axis_tready);
        produces = decode_byte(rx, cl, predicted);
        if (typed)
            expected_results.push_back(fixed_res);
        else if (produces)
            expected_results.push_back(predicted);
        sent_count++;
    endtask

    task automatic drive_pending();
        rx_item_t item;
        while (pending.size() != 0)
        begin
            item = pending.pop_front();
            send_rx(item.rx, item.cl, 1'b0, NO_RESULT);
        end
    endtask

    // The sender holds off until every pending result has drained.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    function automatic void queue_byte(input logic [7:0] b, input logic cl = 1'b0);
        rx_item_t item;
        item.rx = b;
        item.cl = cl;
        pending.push_back(item);
    endfunction

    function automatic logic [7:0] hex_char(input int v, input bit upper);
        if (v < 10) return 8'(8'h30 + v);
        return 8'((upper ? 8'h41 : 8'h61) + v - 10);
    endfunction

    function automatic int queue_hex(input int unsigned v);
        int n;
        n = 1;
        while (n < 8 && (v >> (4 * n)) != 0) n++;
        for (int i = n - 1; i >= 0; i--)
            queue_byte(hex_char(int'((v >> (4 * i)) & 15), 1'($urandom_range(0, 1))));
        return n;
    endfunction

    function automatic logic [7:0] random_blank();
        case ($urandom_range(0, 4))
            0: return 8'h20;
            1: return 8'h09;
            2: return 8'h0D;
            3: return 8'h0B;
            default: return 8'h0C;
        endcase
    endfunction

    function automatic logic [7:0] random_noise();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == hcd_pkg::CHAR_NEWLINE);
        return c;
    endfunction

    function automatic logic [7:0] random_stop(input bit allow_blank);
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (nibble_of(c) >= 0 || c == hcd_pkg::CHAR_NEWLINE
               || (!allow_blank && blank_char(c)));
        return c;
    endfunction

    // Size line with random blanks, prefix, letter case and extension, never
    // longer than the line limit allows.
    function automatic void queue_size_line(input int unsigned size);
        int used;
        int room;
        int fill;
        int form;
        used = 0;
        repeat ($urandom_range(0, 2))
        begin
            queue_byte(random_blank());
            used++;
        end
        form = $urandom_range(0, 3);
        if (form == 1 || form == 2)
        begin
            queue_byte(hcd_pkg::CHAR_ZERO);
            queue_byte(form == 1 ? hcd_pkg::CHAR_LOWER_X : hcd_pkg::CHAR_UPPER_X);
            used += 2;
        end
        else if (form == 3)
        begin
            queue_byte(hcd_pkg::CHAR_ZERO);
            used++;
        end
        used += queue_hex(size);
        if ($urandom_range(0, 1) == 1)
        begin
            room = LINE_LIMIT - 1 - used;
            queue_byte($urandom_range(0, 2) == 0 ? 8'h0D : random_stop(1'b1));
            fill = ($urandom_range(0, 7) == 0) ? room - 1 : $urandom_range(0, 3);
            repeat (fill) queue_byte(random_noise());
        end
        queue_byte(hcd_pkg::CHAR_NEWLINE);
    endfunction

    function automatic void queue_payload(input int unsigned n);
        repeat (n) queue_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic void queue_chunk(input int unsigned size);
        queue_size_line(size);
        queue_payload(size);
        if ($urandom_range(0, 3) != 0)
        begin
            queue_byte(8'h0D);
            queue_byte(hcd_pkg::CHAR_NEWLINE);
        end
        else
        begin
            queue_payload(hcd_pkg::TRAIL_BYTES);
        end
    endfunction

    function automatic int unsigned pick_chunk_size();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 15) return $urandom_range(1, 6);
        if (r < 19) return $urandom_range(7, 40);
        return $urandom_range(41, 300);
    endfunction

    // The stream can close only once per run, so one closing case is drawn.
    function automatic void queue_ending();
        int unsigned size;
        ending = ending_t'($urandom_range(0, 7));
        case (ending)
            END_BY_ZERO:
            begin
                queue_byte(hcd_pkg::CHAR_ZERO);
                if ($urandom_range(0, 1) == 1) queue_byte(8'h0D);
                queue_byte(hcd_pkg::CHAR_NEWLINE);
            end
            END_BY_PREFIX:
            begin
                // A bare prefix reads as a size of zero.
                queue_byte(hcd_pkg::CHAR_ZERO);
                queue_byte($urandom_range(0, 1) == 1 ? hcd_pkg::CHAR_LOWER_X
                                                     : hcd_pkg::CHAR_UPPER_X);
                if ($urandom_range(0, 1) == 1) queue_byte(random_stop(1'b1));
                queue_byte(hcd_pkg::CHAR_NEWLINE);
            end
            END_BY_CLOSE_LINE:
            begin
                repeat ($urandom_range(0, 4)) queue_byte(random_noise());
                queue_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            END_BY_CLOSE_DATA:
            begin
                size = $urandom_range(1, 8);
                queue_size_line(size);
                queue_payload($urandom_range(0, size - 1));
                queue_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            END_BY_CLOSE_TRAIL:
            begin
                size = $urandom_range(1, 8);
                queue_size_line(size);
                queue_payload(size);
                queue_payload($urandom_range(0, 1));
                queue_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            END_BY_LONG_LINE:
            begin
                queue_byte(hex_char(1, 1'b0));
                repeat (LINE_LIMIT - 1) queue_byte(random_noise());
            end
            END_BY_NO_DIGITS:
            begin
                repeat ($urandom_range(0, 2)) queue_byte(random_blank());
                if ($urandom_range(0, 1) == 1)
                begin
                    queue_byte(random_stop(1'b0));
                    repeat ($urandom_range(0, 3)) queue_byte(random_noise());
                end
                queue_byte(hcd_pkg::CHAR_NEWLINE);
            end
            default:
            begin
                case ($urandom_range(0, 3))
                    0: void'(queue_hex(MAX_CHUNK - 1));
                    1: void'(queue_hex(MAX_CHUNK));
                    2: void'(queue_hex($urandom_range(MAX_CHUNK + 1, 1048575)));
                    default: repeat (10) queue_byte(hex_char(15, 1'($urandom_range(0, 1))));
                endcase
                queue_byte(hcd_pkg::CHAR_NEWLINE);
            end
        endcase
        // Everything after the close must be swallowed silently.
        repeat (12) queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endfunction

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        mismatches    = 0;
        results_seen  = 0;
        sent_count    = 0;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        restart_size_line();
        remain    = '0;
        chunk_cnt = '0;

        // Two short chunks: blanks, 0X prefix, extension, payload extremes.
        directed_rows = '{
            '{8'h20,                 1'b0, 1'b0, NO_RESULT},
            '{8'h09,                 1'b0, 1'b0, NO_RESULT},
            '{hcd_pkg::CHAR_ZERO,    1'b0, 1'b0, NO_RESULT},
            '{hcd_pkg::CHAR_UPPER_X, 1'b0, 1'b0, NO_RESULT},
            '{8'h31,                 1'b0, 1'b0, NO_RESULT},
            '{8'h3B,                 1'b0, 1'b0, NO_RESULT},
            '{8'hFF,                 1'b0, 1'b0, NO_RESULT},
            '{hcd_pkg::CHAR_NEWLINE, 1'b0, 1'b0, NO_RESULT},
            '{8'hFF,                 1'b0, 1'b1,
              '{hcd_pkg::KIND_DATA, 8'hFF, 1'b1, 16'd1}},
            '{8'h0D,                 1'b0, 1'b0, NO_RESULT},
            '{hcd_pkg::CHAR_NEWLINE, 1'b0, 1'b0, NO_RESULT},
            '{hcd_pkg::CHAR_ZERO,    1'b0, 1'b0, NO_RESULT},
            '{8'h32,                 1'b0, 1'b0, NO_RESULT},
            '{hcd_pkg::CHAR_NEWLINE, 1'b0, 1'b0, NO_RESULT},
            '{8'h00,                 1'b0, 1'b1,
              '{hcd_pkg::KIND_DATA, 8'h00, 1'b0, 16'd2}},
            '{hcd_pkg::CHAR_NEWLINE, 1'b0, 1'b1,
              '{hcd_pkg::KIND_DATA, 8'h0A, 1'b1, 16'd2}},
            '{8'h00,                 1'b0, 1'b0, NO_RESULT},
            '{8'hFF,                 1'b0, 1'b0, NO_RESULT}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_rx(directed_rows[i].rx, directed_rows[i].cl, directed_rows[i].typed,
                    directed_rows[i].want);
        wait_drained();

        while (sent_count < RANDOM_ITEMS + DIR_ROWS)
        begin
            queue_chunk(pick_chunk_size());
            drive_pending();
        end
        queue_ending();
        drive_pending();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Summary: %0d bytes sent (%0d directed), %0d results checked, %0d chunks.",
                 sent_count, DIR_ROWS, results_seen, chunk_cnt);
        $display("Stream closed by case %s, %0d mismatches.", ending.name(), mismatches);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
